>>> hdl/met_pkg.sv
// Package for the marker edge tracker: widths, register codes, reset values,
// the result beat type and the width saturation helper.
// No dependencies.
package met_pkg;

  localparam int COL_W      = 12;          // column bits
  localparam int WID_W      = COL_W + 1;   // frame width bits (holds 2^COL_W)
  localparam int ROW_W      = 12;
  localparam int PHASE_W    = 8;
  localparam int CH_W       = 8;
  localparam int LIM_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_ROW_STEP     = 3'd1,
    CFG_DARK_LIMIT   = 3'd2,
    CFG_BRIGHT_LIMIT = 3'd3,
    CFG_SEARCH_MARG  = 3'd4,
    CFG_JUMP_BACK    = 3'd5,
    CFG_JUMP_FWD     = 3'd6
  } cfg_idx_t;

  // Side codes
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Register reset values
  localparam logic [WID_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [PHASE_W-1:0] RST_ROW_STEP     = 8'd5;
  localparam logic [CH_W-1:0]    RST_DARK_LIMIT   = 8'd10;
  localparam logic [CH_W-1:0]    RST_BRIGHT_LIMIT = 8'd250;
  localparam logic [LIM_W-1:0]   RST_SEARCH_MARG  = 12'd20;
  localparam logic [LIM_W-1:0]   RST_JUMP_BACK    = 12'd50;
  localparam logic [LIM_W-1:0]   RST_JUMP_FWD     = 12'd10;

  localparam logic [WID_W-1:0]   MAX_WIDTH = WID_W'(1 << COL_W);

  // One result beat
  typedef struct packed {
    logic             side;
    logic [COL_W-1:0] point_x;
    logic [ROW_W-1:0] point_y;
    logic             restart_run;
    logic             last_of_run;
  } point_t;

  // Zero width acts as one, oversize saturates to the column range
  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] fw);
    logic [WID_W-1:0] w;
    w = fw;
    if (fw == '0) begin
      w = WID_W'(1);
    end else if (fw > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    return w;
  endfunction

endpackage

>>> hdl/met_if.sv
// Channel interfaces of the marker edge tracker: pixel in, point out, config write.
// Depends on met_pkg.
interface met_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [met_pkg::CH_W-1:0]  blue;
  logic [met_pkg::CH_W-1:0]  green;
  logic [met_pkg::CH_W-1:0]  red;
  logic                      frame_start;

  modport source (output valid, blue, green, red, frame_start, input ready);
  modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface met_point_if;
  logic                      valid;
  logic                      ready;
  logic                      side;
  logic [met_pkg::COL_W-1:0] point_x;
  logic [met_pkg::ROW_W-1:0] point_y;
  logic                      restart_run;
  logic                      last_of_run;

  modport source (output valid, side, point_x, point_y, restart_run, last_of_run,
                  input ready);
  modport sink   (input valid, side, point_x, point_y, restart_run, last_of_run,
                  output ready);
endinterface

interface met_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [met_pkg::CFG_IDX_W-1:0]  index;
  logic [met_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/marker_edge_tracker_core.sv
// Marker edge tracker top level: config registers, pixel stage, tracking
// update and a four-entry result queue. Depends on met_pkg and met_if.
// Throughput: one pixel per cycle while the result queue has two free entries.
// A row's points queue for out_pt once its last pixel leaves the pixel stage register.
// A row end that yields two points drains at one beat per cycle while out_pt is ready.
// Reset (rst_n low, synchronous): registers to defaults, tracking cleared, queue empty.
module marker_edge_tracker_core (
  input  logic          clk,
  input  logic          rst_n,
  met_pixel_if.sink     in_px,
  met_point_if.source   out_pt,
  met_cfg_if.sink       cfg_wr
);

  localparam int COL_W   = met_pkg::COL_W;
  localparam int WID_W   = met_pkg::WID_W;
  localparam int ROW_W   = met_pkg::ROW_W;
  localparam int PHASE_W = met_pkg::PHASE_W;
  localparam int CH_W    = met_pkg::CH_W;
  localparam int LIM_W   = met_pkg::LIM_W;
  localparam int AW      = met_pkg::FIFO_AW;
  localparam int CW      = met_pkg::FIFO_CW;

  // ---------------- configuration registers ----------------
  logic [WID_W-1:0]   frame_width_r;
  logic [PHASE_W-1:0] row_step_r;
  logic [CH_W-1:0]    dark_limit_r, bright_limit_r;
  logic [LIM_W-1:0]   search_margin_r, jump_back_r, jump_fwd_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= met_pkg::RST_FRAME_WIDTH;
      row_step_r      <= met_pkg::RST_ROW_STEP;
      dark_limit_r    <= met_pkg::RST_DARK_LIMIT;
      bright_limit_r  <= met_pkg::RST_BRIGHT_LIMIT;
      search_margin_r <= met_pkg::RST_SEARCH_MARG;
      jump_back_r     <= met_pkg::RST_JUMP_BACK;
      jump_fwd_r      <= met_pkg::RST_JUMP_FWD;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        met_pkg::CFG_FRAME_WIDTH:  frame_width_r   <= cfg_wr.data[WID_W-1:0];
        met_pkg::CFG_ROW_STEP:     row_step_r      <= cfg_wr.data[PHASE_W-1:0];
        met_pkg::CFG_DARK_LIMIT:   dark_limit_r    <= cfg_wr.data[CH_W-1:0];
        met_pkg::CFG_BRIGHT_LIMIT: bright_limit_r  <= cfg_wr.data[CH_W-1:0];
        met_pkg::CFG_SEARCH_MARG:  search_margin_r <= cfg_wr.data[LIM_W-1:0];
        met_pkg::CFG_JUMP_BACK:    jump_back_r     <= cfg_wr.data[LIM_W-1:0];
        met_pkg::CFG_JUMP_FWD:     jump_fwd_r      <= cfg_wr.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pixel input stage ----------------
  logic            s1_valid_r;
  logic [CH_W-1:0] s1_blue_r, s1_green_r, s1_red_r;
  logic            s1_fs_r;
  logic [CW-1:0]   cnt_r;
  logic            room, adv;

  // two free queue entries cover the worst row end
  assign room        = (cnt_r <= CW'(met_pkg::FIFO_DEPTH - 2));
  assign adv         = s1_valid_r && room;
  assign in_px.ready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_px.ready) begin
      s1_valid_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_px.valid && in_px.ready) begin
      s1_blue_r  <= in_px.blue;
      s1_green_r <= in_px.green;
      s1_red_r   <= in_px.red;
      s1_fs_r    <= in_px.frame_start;
    end
  end

  // ---------------- tracking state ----------------
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [WID_W-1:0]   lpos_r, lpos_nxt;
  logic [COL_W-1:0]   rpos_r, rpos_nxt;
  logic               lact_r, lact_nxt, ract_r, ract_nxt;
  logic               lhv_r, lhv_nxt, rhv_r, rhv_nxt;
  logic [COL_W-1:0]   lhc_r, lhc_nxt, rhc_r, rhc_nxt;

  logic [WID_W-1:0]   width;
  logic [COL_W-1:0]   wm1;
  logic [PHASE_W-1:0] step;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   row_c;
  logic [PHASE_W-1:0] phase_c;
  logic [WID_W-1:0]   lp;
  logic [COL_W-1:0]   rp;
  logic               la, ra, lhv, rhv;
  logic [COL_W-1:0]   lhc, rhc;
  logic               scanned, marker, row_end;
  logic               l_rs, r_rs;
  logic [WID_W-1:0]   l_hx;
  logic [PHASE_W:0]   phase_inc;
  met_pkg::point_t    left_pt, right_pt, p0, p1;
  logic [1:0]         push_cnt;

  always_comb begin
    width = met_pkg::eff_width(frame_width_r);
    wm1   = COL_W'(width - WID_W'(1));
    step  = (row_step_r == '0) ? PHASE_W'(1) : row_step_r;

    // frame start restarts tracking before this pixel is handled
    x       = s1_fs_r ? '0 : col_r;
    row_c   = s1_fs_r ? '0 : row_r;
    phase_c = s1_fs_r ? '0 : phase_r;
    lp      = s1_fs_r ? width : lpos_r;
    rp      = s1_fs_r ? '0 : rpos_r;
    la      = s1_fs_r ? 1'b1 : lact_r;
    ra      = s1_fs_r ? 1'b1 : ract_r;
    lhv     = s1_fs_r ? 1'b0 : lhv_r;
    lhc     = s1_fs_r ? '0 : lhc_r;
    rhv     = s1_fs_r ? 1'b0 : rhv_r;
    rhc     = s1_fs_r ? '0 : rhc_r;

    scanned = (phase_c == '0);
    marker  = (s1_blue_r < dark_limit_r) && (s1_green_r > bright_limit_r) &&
              (s1_red_r < dark_limit_r);

    // hit capture: first marker left of the left window, last right of the right one
    if (scanned && marker) begin
      if (la && !lhv &&
          ({2'b00, x} < ({1'b0, lp} + {2'b00, search_margin_r}))) begin
        lhv = 1'b1;
        lhc = x;
      end
      if (ra && (({1'b0, x} + {1'b0, search_margin_r}) > {1'b0, rp})) begin
        rhv = 1'b1;
        rhc = x;
      end
    end

    row_end = (x >= wm1);

    // jump checks: toward the border against back limit, inward against forward
    l_hx = {1'b0, lhc};
    if (lp >= l_hx) begin
      l_rs = (lp - l_hx) > {1'b0, jump_back_r};
    end else begin
      l_rs = (l_hx - lp) > {1'b0, jump_fwd_r};
    end
    if (rhc >= rp) begin
      r_rs = (rhc - rp) > jump_back_r;
    end else begin
      r_rs = (rp - rhc) > jump_fwd_r;
    end

    left_pt.side         = met_pkg::SIDE_LEFT;
    left_pt.point_x      = lhc;
    left_pt.point_y      = row_c;
    left_pt.restart_run  = l_rs;
    left_pt.last_of_run  = !rhv;
    right_pt.side        = met_pkg::SIDE_RIGHT;
    right_pt.point_x     = rhc;
    right_pt.point_y     = row_c;
    right_pt.restart_run = r_rs;
    right_pt.last_of_run = 1'b1;
    p0 = lhv ? left_pt : right_pt;
    p1 = right_pt;

    // defaults: carry the hit state forward
    col_nxt   = x + COL_W'(1);
    row_nxt   = row_c;
    phase_nxt = phase_c;
    lpos_nxt  = lp;
    rpos_nxt  = rp;
    lact_nxt  = la;
    ract_nxt  = ra;
    lhv_nxt   = lhv;
    lhc_nxt   = lhc;
    rhv_nxt   = rhv;
    rhc_nxt   = rhc;
    push_cnt  = 2'd0;
    phase_inc = {1'b0, phase_c} + (PHASE_W+1)'(1);

    // row end: emit points, move positions (scanned rows), advance row counters
    if (row_end) begin
      if (scanned) begin
        push_cnt = {1'b0, lhv} + {1'b0, rhv};
        if (lhv) begin
          lpos_nxt = {1'b0, lhc};
          if (lhc == '0) lact_nxt = 1'b0;
        end
        if (rhv) begin
          rpos_nxt = rhc;
          if (rhc == wm1) ract_nxt = 1'b0;
        end
      end
      lhv_nxt   = 1'b0;
      lhc_nxt   = '0;
      rhv_nxt   = 1'b0;
      rhc_nxt   = '0;
      col_nxt   = '0;
      row_nxt   = row_c + ROW_W'(1);
      phase_nxt = (phase_inc >= {1'b0, step}) ? '0 : phase_inc[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      lpos_r  <= met_pkg::eff_width(met_pkg::RST_FRAME_WIDTH);
      rpos_r  <= '0;
      lact_r  <= 1'b1;
      ract_r  <= 1'b1;
      lhv_r   <= 1'b0;
      lhc_r   <= '0;
      rhv_r   <= 1'b0;
      rhc_r   <= '0;
    end else if (adv) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      lpos_r  <= lpos_nxt;
      rpos_r  <= rpos_nxt;
      lact_r  <= lact_nxt;
      ract_r  <= ract_nxt;
      lhv_r   <= lhv_nxt;
      lhc_r   <= lhc_nxt;
      rhv_r   <= rhv_nxt;
      rhc_r   <= rhc_nxt;
    end
  end

  // ---------------- result queue ----------------
  met_pkg::point_t fifo_r [met_pkg::FIFO_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [1:0]      push;
  logic            pop;
  met_pkg::point_t head;

  assign push = adv ? push_cnt : 2'd0;
  assign pop  = out_pt.valid && out_pt.ready;
  assign head = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push != 2'd0) fifo_r[wp_r] <= p0;
    if (push == 2'd2) fifo_r[wp_r + AW'(1)] <= p1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign out_pt.valid       = (cnt_r != '0);
  assign out_pt.side        = head.side;
  assign out_pt.point_x     = head.point_x;
  assign out_pt.point_y     = head.point_y;
  assign out_pt.restart_run = head.restart_run;
  assign out_pt.last_of_run = head.last_of_run;

  // ---------------- assertions ----------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(met_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push == 2'd2) |=> (cnt_r >= CW'(2)))
    else $error("two-point row end lost an entry");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && row_end) |=> (col_r == '0) && !lhv_r && !rhv_r)
    else $error("row end did not clear column and hits");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !room) |=> s1_valid_r && $stable(s1_blue_r))
    else $error("stalled pixel stage changed");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for marker_edge_tracker_core: drives BGR pixel beats, predicts the
// left/right edge points per scanned row and checks every point beat in order.
// Depends on met_pkg, the met_*_if interfaces and the core.
module tb_top;

  localparam int CH_W       = met_pkg::CH_W;
  localparam int COL_W      = met_pkg::COL_W;
  localparam int WID_W      = met_pkg::WID_W;
  localparam int ROW_W      = met_pkg::ROW_W;
  localparam int PHASE_W    = met_pkg::PHASE_W;
  localparam int LIM_W      = met_pkg::LIM_W;
  localparam int CFG_DATA_W = met_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
  } bgr_t;

  logic clk = 1'b0;
  logic rst_n;

  met_pixel_if px_if();
  met_point_if pt_if();
  met_cfg_if   cfg_if();

  marker_edge_tracker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px_if),
    .out_pt (pt_if),
    .cfg_wr (cfg_if)
  );

  always #2 clk = ~clk;

  // Register shadow
  logic [WID_W-1:0]   width_reg;
  logic [PHASE_W-1:0] step_reg;
  logic [CH_W-1:0]    dark_reg, bright_reg;
  logic [LIM_W-1:0]   margin_reg, back_reg, fwd_reg;

  // Tracking state of the predictor
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [PHASE_W-1:0] phase_cnt;
  logic [WID_W-1:0]   left_pos;
  logic [COL_W-1:0]   right_pos;
  logic               left_on, right_on, left_found, right_found;
  logic [COL_W-1:0]   left_col, right_col;

  met_pkg::point_t expected_points[$];
  int     mismatch_count = 0;

  // Sender and receiver pacing
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_request = 0;
  int random_pixels = 0;

  function automatic int active_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > (1 << COL_W)) w = 1 << COL_W;
    return w;
  endfunction

  function automatic void restart_frame();
    col_cnt     = '0;
    row_cnt     = '0;
    phase_cnt   = '0;
    left_pos    = WID_W'(active_width());
    right_pos   = '0;
    left_on     = 1'b1;
    right_on    = 1'b1;
    left_found  = 1'b0;
    right_found = 1'b0;
    left_col    = '0;
    right_col   = '0;
  endfunction

  function automatic void load_defaults();
    width_reg  = met_pkg::RST_FRAME_WIDTH;
    step_reg   = met_pkg::RST_ROW_STEP;
    dark_reg   = met_pkg::RST_DARK_LIMIT;
    bright_reg = met_pkg::RST_BRIGHT_LIMIT;
    margin_reg = met_pkg::RST_SEARCH_MARG;
    back_reg   = met_pkg::RST_JUMP_BACK;
    fwd_reg    = met_pkg::RST_JUMP_FWD;
    restart_frame();
  endfunction

  function automatic void apply_register(input met_pkg::cfg_idx_t idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      met_pkg::CFG_FRAME_WIDTH:  width_reg  = val;
      met_pkg::CFG_ROW_STEP:     step_reg   = val[PHASE_W-1:0];
      met_pkg::CFG_DARK_LIMIT:   dark_reg   = val[CH_W-1:0];
      met_pkg::CFG_BRIGHT_LIMIT: bright_reg = val[CH_W-1:0];
      met_pkg::CFG_SEARCH_MARG:  margin_reg = val[LIM_W-1:0];
      met_pkg::CFG_JUMP_BACK:    back_reg   = val[LIM_W-1:0];
      met_pkg::CFG_JUMP_FWD:     fwd_reg    = val[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // Edge tracking for one accepted pixel; queues the points of a finished row
  function automatic void track_pixel(input bgr_t px, input logic fs);
    int w, stp, x, lp, rp, mg, jb, jf, hx, ph;
    logic scanned, mark;
    met_pkg::point_t pt;
    if (fs) restart_frame();
    w   = active_width();
    stp = (step_reg == 0) ? 1 : int'(step_reg);
    x   = col_cnt;
    lp  = left_pos;
    rp  = right_pos;
    mg  = margin_reg;
    jb  = back_reg;
    jf  = fwd_reg;
    scanned = (phase_cnt == 0);
    mark = (px.b < dark_reg) && (px.g > bright_reg) && (px.r < dark_reg);

    if (scanned && mark) begin
      if (left_on && !left_found && x < lp + mg) begin
        left_found = 1'b1;
        left_col   = COL_W'(x);
      end
      if (right_on && x > rp - mg) begin
        right_found = 1'b1;
        right_col   = COL_W'(x);
      end
    end

    if (x >= w - 1) begin
      if (scanned) begin
        if (left_found) begin
          hx = left_col;
          pt.side        = met_pkg::SIDE_LEFT;
          pt.point_x     = left_col;
          pt.point_y     = row_cnt;
          pt.restart_run = (lp - hx > jb) || (hx - lp > jf);
          pt.last_of_run = !right_found;
          expected_points = {expected_points, pt};
          left_pos = WID_W'(hx);
          if (hx == 0) left_on = 1'b0;
        end
        if (right_found) begin
          hx = right_col;
          pt.side        = met_pkg::SIDE_RIGHT;
          pt.point_x     = right_col;
          pt.point_y     = row_cnt;
          pt.restart_run = (hx - rp > jb) || (rp - hx > jf);
          pt.last_of_run = 1'b1;
          expected_points = {expected_points, pt};
          right_pos = right_col;
          if (hx == w - 1) right_on = 1'b0;
        end
      end
      left_found  = 1'b0;
      left_col    = '0;
      right_found = 1'b0;
      right_col   = '0;
      col_cnt     = '0;
      row_cnt     = row_cnt + 1'b1;
      ph          = phase_cnt;
      phase_cnt   = (ph + 1 >= stp) ? '0 : PHASE_W'(ph + 1);
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  function automatic bgr_t marker_pixel();
    bgr_t px;
    px = 24'($urandom);
    if (dark_reg != 0 && bright_reg != 8'hFF) begin
      px.b = CH_W'($urandom_range(0, dark_reg - 1));
      px.r = CH_W'($urandom_range(0, dark_reg - 1));
      px.g = CH_W'($urandom_range(bright_reg + 1, 255));
    end
    return px;
  endfunction

  // Mostly random color, sometimes a marker with one channel sitting on its limit
  function automatic bgr_t plain_pixel();
    bgr_t px;
    px = marker_pixel();
    case ($urandom_range(0, 7))
      0: px.b = dark_reg;
      1: px.r = dark_reg;
      2: px.g = bright_reg;
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  // One pixel beat; with gaps on, a burst may start with a random gap
  task automatic send_pixel(input bgr_t px, input logic fs);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        px_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    px_if.valid       <= 1'b1;
    px_if.blue        <= px.b;
    px_if.green       <= px.g;
    px_if.red         <= px.r;
    px_if.frame_start <= fs;
    do @(posedge clk); while (px_if.ready !== 1'b1);
    track_pixel(px, fs);
  endtask

  // count pixels; markers at set bits of marks and at far_col
  task automatic send_row(input int count, input logic [31:0] marks, input int far_col,
                          input logic fs);
    logic mark;
    for (int c = 0; c < count; c++) begin
      mark = (c < 32 && marks[c]) || c == far_col;
      send_pixel(mark ? marker_pixel() : plain_pixel(), fs && c == 0);
    end
  endtask

  // Stop sending, let all points drain, then allow for the output latency
  task automatic wait_idle();
    px_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input met_pkg::cfg_idx_t idx, input int val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    apply_register(idx, CFG_DATA_W'(val));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int fw, input int stp, input int dark, input int bright,
                           input int margin, input int back, input int fwd);
    wait_idle();
    write_reg(met_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(met_pkg::CFG_ROW_STEP, stp);
    write_reg(met_pkg::CFG_DARK_LIMIT, dark);
    write_reg(met_pkg::CFG_BRIGHT_LIMIT, bright);
    write_reg(met_pkg::CFG_SEARCH_MARG, margin);
    write_reg(met_pkg::CFG_JUMP_BACK, back);
    write_reg(met_pkg::CFG_JUMP_FWD, fwd);
  endtask

  // Reset values of limits, step and left position; only the width is narrowed
  task automatic test_reset_values();
    write_reg(met_pkg::CFG_FRAME_WIDTH, 16);
    for (int i = 0; i < 6; i++) begin
      send_row(16, (i == 5) ? 32'h0410 : 32'h0220, 14, 1'b0);
    end
  endtask

  // Color limit extremes
  task automatic test_color_limits();
    configure(8, 1, 0, 250, 20, 50, 10);
    send_row(8, 32'h81, -1, 1'b1);
    send_row(8, 32'h3C, -1, 1'b0);
    configure(8, 1, 255, 0, 20, 50, 10);
    send_row(8, 32'h42, -1, 1'b1);
    send_row(8, 32'h24, -1, 1'b0);
    configure(8, 1, 255, 255, 20, 50, 10);
    send_row(8, 32'hFF, -1, 1'b1);
  endtask

  // Windows, restart thresholds, border stop, frame restart
  task automatic test_tracking();
    logic [31:0] rows_a[9] = '{32'h1400, 32'h4040, 32'h1100, 32'h0208, 32'hA030,
                               32'h4001, 32'h0404, 32'h0082, 32'h0000};
    configure(16, 1, 10, 250, 3, 4, 2);
    foreach (rows_a[i]) send_row(16, rows_a[i], -1, i == 7);
    configure(16, 1, 10, 250, 0, 0, 0);
    foreach (rows_a[i]) send_row(16, rows_a[i], -1, i == 0);
  endtask

  // Row step zero, small and maximum
  task automatic test_row_step();
    configure(4, 0, 10, 250, 20, 50, 10);
    for (int i = 0; i < 4; i++) send_row(4, 32'h6, -1, i == 0);
    configure(4, 3, 10, 250, 20, 50, 10);
    for (int i = 0; i < 7; i++) send_row(4, 32'h6, -1, i == 0);
    // only row 0 and row 255 are scanned; the marker sits on row 255
    configure(1, 255, 10, 250, 20, 4095, 4095);
    for (int i = 0; i < 256; i++) send_row(1, (i == 255) ? 32'h1 : 32'h0, -1, i == 0);
  endtask

  // Zero width, saturated width, width lowered mid-row
  task automatic test_width_edges();
    configure(0, 1, 10, 250, 20, 50, 10);
    for (int i = 0; i < 4; i++) send_row(1, 32'h1, -1, i == 0);
    // saturated width shows in the left start position; the row is cut short
    configure(8191, 1, 10, 250, 20, 4095, 4095);
    send_row(3, 32'h2, -1, 1'b1);
    configure(4, 1, 10, 250, 20, 4095, 4095);
    send_row(1, 32'h0, -1, 1'b0);
    configure(16, 1, 10, 250, 20, 50, 10);
    send_row(10, 32'h4, -1, 1'b1);
    configure(4, 1, 10, 250, 20, 50, 10);
    send_row(1, 32'h1, -1, 1'b0);
    send_row(4, 32'h2, -1, 1'b0);
  endtask

  // Receiver holds off long enough for the point queue to fill and stall the input
  task automatic test_backpressure();
    configure(4, 1, 10, 250, 4095, 4095, 4095);
    gaps_on = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 20; i++) send_row(4, 32'h6, -1, i == 0);
    gaps_on = 1'b1;
  endtask

  // Drifting edges with noise markers and stray frame starts
  task automatic random_frame();
    int w, rows, lcol, rcol, t;
    logic fs;
    bgr_t px;
    w = active_width();
    rows = (w > 24) ? 2 : $urandom_range(2, 10);
    lcol = $urandom_range(0, w - 1);
    rcol = $urandom_range(0, w - 1);
    if (lcol > rcol) begin
      t = lcol;
      lcol = rcol;
      rcol = t;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        fs = (r == 0 && c == 0) || $urandom_range(0, 199) == 0;
        if (c == lcol || c == rcol || $urandom_range(0, 15) == 0) px = marker_pixel();
        else px = plain_pixel();
        send_pixel(px, fs);
        random_pixels++;
      end
      lcol = lcol + $urandom_range(0, 6) - 3;
      rcol = rcol + $urandom_range(0, 6) - 3;
      if ($urandom_range(0, 7) == 0) lcol = $urandom_range(0, w - 1);
      if ($urandom_range(0, 7) == 0) rcol = $urandom_range(0, w - 1);
      if ($urandom_range(0, 9) == 0) lcol = -1;
      if ($urandom_range(0, 9) == 0) rcol = w + 4;
      if (lcol >= w) lcol = w - 1;
      if (rcol < 0) rcol = 0;
    end
  endtask

  task automatic test_random();
    int fw, stp, mg, jb, jf;
    while (random_pixels < 100) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       fw = $urandom_range(0, 1);
        1:       fw = $urandom_range(25, 60);
        default: fw = $urandom_range(2, 24);
      endcase
      stp = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
      mg  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
      jb  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
      jf  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
      configure(fw, stp, $urandom_range(1, 255), $urandom_range(0, 254), mg, jb, jf);
      repeat ($urandom_range(1, 3)) random_frame();
    end
    gaps_on = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Point beat checker
  always @(posedge clk) begin : check_beat
    met_pkg::point_t want;
    if (rst_n === 1'b1 && pt_if.valid === 1'b1 && pt_if.ready === 1'b1) begin
      if (expected_points.size() == 0) begin
        $display("%0t: point beat with none expected: side=%0d x=%0d y=%0d", $time,
                 pt_if.side, pt_if.point_x, pt_if.point_y);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        compare_field("side", 16'(want.side), 16'(pt_if.side));
        compare_field("point_x", 16'(want.point_x), 16'(pt_if.point_x));
        compare_field("point_y", 16'(want.point_y), 16'(pt_if.point_y));
        compare_field("restart_run", 16'(want.restart_run), 16'(pt_if.restart_run));
        compare_field("last_of_run", 16'(want.last_of_run), 16'(pt_if.last_of_run));
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int rx_cycle, hold_left, stall_mode;
    rx_cycle   = 0;
    hold_left  = 0;
    stall_mode = 0;
    pt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pt_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       pt_if.ready <= 1'b1;
          1:       pt_if.ready <= ($urandom_range(0, 3) != 0);
          2:       pt_if.ready <= ($urandom_range(0, 1) != 0);
          default: pt_if.ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    px_if.valid       <= 1'b0;
    px_if.blue        <= '0;
    px_if.green       <= '0;
    px_if.red         <= '0;
    px_if.frame_start <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= met_pkg::CFG_FRAME_WIDTH;
    cfg_if.data       <= '0;
    load_defaults();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_color_limits();
    test_tracking();
    test_row_step();
    test_width_edges();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
